/* rtl/core/vclt_pkg.sv */
// ----------------------------------------------------------------------------
// vclt_pkg
// Shared widths, codes and helpers for the voxel chunk translator.
// ----------------------------------------------------------------------------
package vclt_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned KEY_W     = 3 * COORD_W;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned SIDE_W    = 4;
  localparam int unsigned LIMIT_W   = 7;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned OFS_W     = 8;
  localparam int unsigned MORTON_W  = 3 * OFS_W;
  localparam int unsigned SLOT_O_W  = 6;
  localparam int unsigned SIDE_MAX  = 8;
  localparam int unsigned LIMIT_MIN = 32;

  // Configuration register indexes
  typedef enum logic {
    CFG_SIDE  = 1'b0,
    CFG_LIMIT = 1'b1
  } cfg_idx_e;

  // Request function codes
  localparam logic FUNC_ACCESS = 1'b0;
  localparam logic FUNC_FLUSH  = 1'b1;

  // Spread each offset bit i to position 3i
  function automatic logic [MORTON_W-1:0] spread3(logic [OFS_W-1:0] v);
    logic [MORTON_W-1:0] r;
    r = '0;
    for (int i = 0; i < OFS_W; i++) begin
      r[3*i] = v[i];
    end
    return r;
  endfunction

endpackage

/* rtl/core/voxel_chunk_lru_translator_unit.sv */
// A flush goes straight to the response state; a repeat of the most recent chunk answers
// from the lookup state. Other accesses scan the key RAM one slot a cycle until a hit or
// the last slot; a miss then allocates a slot and, if the count reaches the limit, scans
// the stamp RAM for the oldest stamp and reads the victim key before the response.
// One request at a time; the next is taken once the result sits in the output register.
// Reset: all slots invalid, stamp counter and recent chunk cleared, registers 5 and 32.
// ----------------------------------------------------------------------------
// voxel_chunk_lru_translator_unit
// Fully associative chunk table with oldest-stamp eviction and Morton offset.
// ----------------------------------------------------------------------------
module voxel_chunk_lru_translator_unit #(
  parameter int unsigned SLOT_COUNT = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [vclt_pkg::CFG_W-1:0]     cfg_data_i,
  // request
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           func_i,
  input  logic [vclt_pkg::COORD_W-1:0]   voxel_x_i,
  input  logic [vclt_pkg::COORD_W-1:0]   voxel_y_i,
  input  logic [vclt_pkg::COORD_W-1:0]   voxel_z_i,
  // result
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           hit_o,
  output logic [vclt_pkg::SLOT_O_W-1:0]  slot_o,
  output logic [vclt_pkg::MORTON_W-1:0]  voxel_index_o,
  output logic [vclt_pkg::COORD_W-1:0]   chunk_x_o,
  output logic [vclt_pkg::COORD_W-1:0]   chunk_y_o,
  output logic [vclt_pkg::COORD_W-1:0]   chunk_z_o,
  output logic                           evicted_o,
  output logic [vclt_pkg::COORD_W-1:0]   evicted_x_o,
  output logic [vclt_pkg::COORD_W-1:0]   evicted_y_o,
  output logic [vclt_pkg::COORD_W-1:0]   evicted_z_o
);

  import vclt_pkg::*;

  localparam int unsigned SW = $clog2(SLOT_COUNT);
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_SCAN, S_ALLOC, S_CHECK, S_ESCAN, S_EREQ, S_EDATA, S_RESP
  } state_e;

  // Control state
  state_e               state_q;
  logic [SIDE_W-1:0]    side_q;
  logic [LIMIT_W-1:0]   limit_q;
  logic [SLOT_COUNT-1:0] valid_q;
  logic [CW-1:0]        cnt_q;
  logic [STAMP_W-1:0]   stamp_q;
  logic [KEY_W-1:0]     recent_key_q;
  logic                 recent_valid_q;
  logic [SW-1:0]        recent_slot_q;
  logic [SW:0]          scan_q;
  logic                 cmp_en_q;
  logic                 free_found_q;
  logic                 got_q;
  logic                 out_valid_q;

  // Datapath registers
  logic [KEY_W-1:0]     key_q;
  logic [MORTON_W-1:0]  idx_q;
  logic                 hit_q;
  logic [SW-1:0]        slot_q;
  logic                 ev_q;
  logic [KEY_W-1:0]     ev_key_q;
  logic [SW-1:0]        cmp_idx_q;
  logic [SW-1:0]        free_slot_q;
  logic [SW-1:0]        victim_q;
  logic [STAMP_W-1:0]   best_q;

  logic                 out_hit_q;
  logic [SW-1:0]        out_slot_q;
  logic [MORTON_W-1:0]  out_idx_q;
  logic [KEY_W-1:0]     out_key_q;
  logic                 out_ev_q;
  logic [KEY_W-1:0]     out_ev_key_q;

  // RAM ports
  logic                 key_we, stamp_we;
  logic [SW-1:0]        key_waddr, stamp_waddr, key_raddr;
  logic [KEY_W-1:0]     key_rdata;
  logic [STAMP_W-1:0]   stamp_rdata;

  // Request split into chunk coordinates and Morton offset
  logic [SIDE_W-1:0]    side_eff;
  logic [OFS_W-1:0]     ofs_mask;
  logic [KEY_W-1:0]     in_key;
  logic [MORTON_W-1:0]  in_idx;

  // Control helpers
  logic                 in_acc;
  logic                 recent_hit;
  logic                 cmp_valid;
  logic                 scan_hit;
  logic                 cmp_last;
  logic                 scan_issue;
  logic                 stamp_less;
  logic [SW-1:0]        alloc_slot;
  logic [LW-1:0]        lim_ext, lim_eff;
  logic                 at_limit;

  assign side_eff = (side_q > SIDE_W'(SIDE_MAX)) ? SIDE_W'(SIDE_MAX) : side_q;
  assign ofs_mask = OFS_W'((9'd1 << side_eff) - 9'd1);
  assign in_key   = {COORD_W'($signed(voxel_x_i) >>> side_eff),
                     COORD_W'($signed(voxel_y_i) >>> side_eff),
                     COORD_W'($signed(voxel_z_i) >>> side_eff)};
  assign in_idx   = spread3(voxel_x_i[OFS_W-1:0] & ofs_mask)
                  | (spread3(voxel_y_i[OFS_W-1:0] & ofs_mask) << 1)
                  | (spread3(voxel_z_i[OFS_W-1:0] & ofs_mask) << 2);

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign recent_hit = recent_valid_q && (recent_key_q == key_q);
  assign cmp_valid  = cmp_en_q && valid_q[cmp_idx_q];
  assign scan_hit   = cmp_valid && (key_rdata == key_q);
  assign cmp_last   = cmp_en_q && (cmp_idx_q == SW'(SLOT_COUNT - 1));
  assign scan_issue = (scan_q < (SW+1)'(SLOT_COUNT));
  assign stamp_less = cmp_valid && (stamp_rdata < best_q);
  assign alloc_slot = free_found_q ? free_slot_q : '0;

  // Clamp the eviction threshold to the legal window
  assign lim_ext  = LW'(limit_q);
  assign lim_eff  = (lim_ext < LW'(LIMIT_MIN)) ? LW'(LIMIT_MIN) :
                    (lim_ext > LW'(SLOT_COUNT)) ? LW'(SLOT_COUNT) : lim_ext;
  assign at_limit = (LW'(cnt_q) >= lim_eff);

  // RAM control
  assign key_we      = (state_q == S_ALLOC);
  assign key_waddr   = alloc_slot;
  assign key_raddr   = (state_q == S_EREQ) ? victim_q : scan_q[SW-1:0];
  assign stamp_we    = (state_q == S_ALLOC) || ((state_q == S_SCAN) && scan_hit);
  assign stamp_waddr = (state_q == S_ALLOC) ? alloc_slot : cmp_idx_q;

  vclt_ram #(.WIDTH(KEY_W), .DEPTH(SLOT_COUNT)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_q),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  vclt_ram #(.WIDTH(STAMP_W), .DEPTH(SLOT_COUNT)) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (stamp_we),
    .waddr_i (stamp_waddr),
    .wdata_i (stamp_q),
    .raddr_i (scan_q[SW-1:0]),
    .rdata_o (stamp_rdata)
  );

  // Sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      side_q         <= SIDE_W'(5);
      limit_q        <= LIMIT_W'(32);
      valid_q        <= '0;
      cnt_q          <= '0;
      stamp_q        <= '0;
      recent_key_q   <= '0;
      recent_valid_q <= 1'b0;
      recent_slot_q  <= '0;
      scan_q         <= '0;
      cmp_en_q       <= 1'b0;
      free_found_q   <= 1'b0;
      got_q          <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      // Configuration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_SIDE:  side_q  <= cfg_data_i[SIDE_W-1:0];
          CFG_LIMIT: limit_q <= cfg_data_i[LIMIT_W-1:0];
          default:   ;
        endcase
      end

      // Drop the result once taken, unless the response state loads a new one
      if (out_valid_q && out_ready_i && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (func_i == FUNC_FLUSH) begin
              valid_q        <= '0;
              cnt_q          <= '0;
              recent_valid_q <= 1'b0;
              state_q        <= S_RESP;
            end else begin
              state_q <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          if (recent_hit) begin
            state_q <= S_RESP;
          end else begin
            stamp_q      <= stamp_q + STAMP_W'(1);
            scan_q       <= '0;
            cmp_en_q     <= 1'b0;
            free_found_q <= 1'b0;
            state_q      <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_en_q <= scan_issue;
          if (scan_issue) begin
            scan_q <= scan_q + (SW+1)'(1);
          end
          if (cmp_en_q && !valid_q[cmp_idx_q] && !free_found_q) begin
            free_found_q <= 1'b1;
          end
          if (scan_hit) begin
            recent_valid_q <= 1'b1;
            recent_key_q   <= key_q;
            recent_slot_q  <= cmp_idx_q;
            state_q        <= S_RESP;
          end else if (cmp_last) begin
            state_q <= S_ALLOC;
          end
        end
        S_ALLOC: begin
          valid_q[alloc_slot] <= 1'b1;
          if (free_found_q) begin
            cnt_q <= cnt_q + CW'(1);
          end
          recent_valid_q <= 1'b1;
          recent_key_q   <= key_q;
          recent_slot_q  <= alloc_slot;
          state_q        <= S_CHECK;
        end
        S_CHECK: begin
          if (at_limit) begin
            scan_q   <= '0;
            cmp_en_q <= 1'b0;
            got_q    <= 1'b0;
            state_q  <= S_ESCAN;
          end else begin
            state_q <= S_RESP;
          end
        end
        S_ESCAN: begin
          cmp_en_q <= scan_issue;
          if (scan_issue) begin
            scan_q <= scan_q + (SW+1)'(1);
          end
          if (stamp_less) begin
            got_q <= 1'b1;
          end
          if (cmp_last) begin
            state_q <= (got_q || stamp_less) ? S_EREQ : S_RESP;
          end
        end
        S_EREQ: begin
          state_q <= S_EDATA;
        end
        S_EDATA: begin
          valid_q[victim_q] <= 1'b0;
          cnt_q             <= cnt_q - CW'(1);
          state_q           <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Working and result payload
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          hit_q    <= 1'b0;
          slot_q   <= '0;
          ev_q     <= 1'b0;
          ev_key_q <= '0;
          if (func_i == FUNC_FLUSH) begin
            key_q <= '0;
            idx_q <= '0;
          end else begin
            key_q <= in_key;
            idx_q <= in_idx;
          end
        end
      end
      S_LOOK: begin
        if (recent_hit) begin
          hit_q  <= 1'b1;
          slot_q <= recent_slot_q;
        end
      end
      S_SCAN: begin
        cmp_idx_q <= scan_q[SW-1:0];
        if (cmp_en_q && !valid_q[cmp_idx_q] && !free_found_q) begin
          free_slot_q <= cmp_idx_q;
        end
        if (scan_hit) begin
          hit_q  <= 1'b1;
          slot_q <= cmp_idx_q;
        end
      end
      S_ALLOC: begin
        hit_q  <= 1'b0;
        slot_q <= alloc_slot;
      end
      S_CHECK: begin
        best_q <= '1;
      end
      S_ESCAN: begin
        cmp_idx_q <= scan_q[SW-1:0];
        if (stamp_less) begin
          best_q   <= stamp_rdata;
          victim_q <= cmp_idx_q;
        end
      end
      S_EDATA: begin
        ev_q     <= 1'b1;
        ev_key_q <= key_rdata;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_hit_q    <= hit_q;
          out_slot_q   <= slot_q;
          out_idx_q    <= idx_q;
          out_key_q    <= key_q;
          out_ev_q     <= ev_q;
          out_ev_key_q <= ev_key_q;
        end
      end
      default: ;
    endcase
  end

  // Outputs
  assign out_valid_o   = out_valid_q;
  assign hit_o         = out_hit_q;
  assign slot_o        = SLOT_O_W'(out_slot_q);
  assign voxel_index_o = out_idx_q;
  assign chunk_x_o     = out_key_q[3*COORD_W-1:2*COORD_W];
  assign chunk_y_o     = out_key_q[2*COORD_W-1:COORD_W];
  assign chunk_z_o     = out_key_q[COORD_W-1:0];
  assign evicted_o     = out_ev_q;
  assign evicted_x_o   = out_ev_key_q[3*COORD_W-1:2*COORD_W];
  assign evicted_y_o   = out_ev_key_q[2*COORD_W-1:COORD_W];
  assign evicted_z_o   = out_ev_key_q[COORD_W-1:0];

  // Resident count tracks the valid bits
  a_cnt_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(cnt_q))
    else $error("resident count out of step with valid bits");

  // Flush leaves the table empty
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && func_i == FUNC_FLUSH) |=> (valid_q == '0 && !recent_valid_q))
    else $error("flush did not clear the table");

  // A result appears only from the response state
  a_resp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESP))
    else $error("result raised outside the response state");

  // Eviction only after a key scan found no match
  a_evict_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EDATA) |-> (!hit_q && $past(state_q == S_EREQ)))
    else $error("eviction on a hit");

endmodule

/* rtl/core/vclt_ram.sv */
// ----------------------------------------------------------------------------
// vclt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vclt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
